@@ rtl/faqt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// faqt_pkg
// Shared types and codes for the freed address quarantine table.
// ----------------------------------------------------------------------------
package faqt_pkg;

  localparam int AddrW = 48;
  localparam int SizeW = 40;
  localparam int HeldW = 46;
  localparam int AgeW  = 64;
  localparam int CntW  = 32;

  // request codes
  localparam logic [2:0] REQ_RECORD = 3'd0;
  localparam logic [2:0] REQ_DCHECK = 3'd1;
  localparam logic [2:0] REQ_LOOKUP = 3'd2;
  localparam logic [2:0] REQ_FORGET = 3'd3;
  localparam logic [2:0] REQ_CLEAR  = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_HIST  = 2'd0;
  localparam logic [1:0] CFG_QLIM  = 2'd1;
  localparam logic [1:0] CFG_ABORT = 2'd2;

  typedef struct packed {
    logic [2:0]       req_type;
    logic [AddrW-1:0] addr;
    logic [SizeW-1:0] obj_size;
  } req_t;

  typedef struct packed {
    logic             kind;
    logic [AddrW-1:0] out_addr;
    logic             hit;
    logic             keep_quarantined;
    logic             abort_request;
    logic [CntW-1:0]  double_free_total;
    logic             last;
  } res_t;

  // running scan flags from the scanner to the sequencer
  typedef struct packed {
    logic match;
    logic any_valid;
    logic any_free;
  } scan_t;

endpackage

@@ rtl/faqt_scan.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// faqt_scan
// Shared compare unit: walks the table one slot a cycle while step is high,
// tracking the first address match, the first free slot and the oldest valid entry.
// ----------------------------------------------------------------------------
module faqt_scan #(
  parameter int IdxW = 5
) (
  input  logic                     clk,
  input  logic                     clear,
  input  logic                     step,
  input  logic [IdxW-1:0]          slot,
  input  logic                     slot_valid,
  input  logic                     addr_eq,
  input  logic [faqt_pkg::AgeW-1:0] slot_age,
  output faqt_pkg::scan_t          flags,
  output logic [IdxW-1:0]          match_idx,
  output logic [IdxW-1:0]          free_idx,
  output logic [IdxW-1:0]          old_idx
);
  import faqt_pkg::*;

  logic [AgeW-1:0] old_age;

  // running search over slots, lowest index wins ties
  always_ff @(posedge clk) begin
    if (clear) begin
      flags <= '0;
    end else if (step) begin
      if (slot_valid && addr_eq && !flags.match) begin
        flags.match <= 1'b1;
        match_idx   <= slot;
      end
      if (!slot_valid && !flags.any_free) begin
        flags.any_free <= 1'b1;
        free_idx       <= slot;
      end
      if (slot_valid && (!flags.any_valid || slot_age < old_age)) begin
        flags.any_valid <= 1'b1;
        old_idx         <= slot;
        old_age         <= slot_age;
      end
    end
  end

endmodule

@@ rtl/freed_address_quarantine_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// freed_address_quarantine_table
// History of recently freed addresses with quarantine byte accounting.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  request  | start / busy         | req (req_t)
//  config   | cfg_valid/cfg_ready  | cfg_index, cfg_data
//  result   | res_valid strobe     | res (res_t), one cycle each
//
// Every pass walks the table one slot a cycle through the single compare unit.
// Lookup, check, forget and unknown requests hold busy through a scan pass, a
// decide step and an answer step. A record free adds a rescan pass; a full
// table adds an eviction step, and each further eviction adds another eviction
// step and rescan pass. A clear adds a rescan pass, then an eviction step and a
// rescan pass per valid entry. Reset clears valid bits at once.
// Results cannot be stalled; the answer is on the ports in the cycle busy falls.
// ----------------------------------------------------------------------------
module freed_address_quarantine_table #(
  parameter int HISTORY_DEPTH = 32,
  parameter int ADDR_BITS     = 48
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  faqt_pkg::req_t      req,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [63:0]         cfg_data,
  output logic                res_valid,
  output faqt_pkg::res_t      res
);
  import faqt_pkg::*;

  localparam int IdxW = $clog2(HISTORY_DEPTH);
  localparam int NumW = $clog2(HISTORY_DEPTH + 1);
  localparam logic [NumW-1:0] LastSlot = NumW'(HISTORY_DEPTH - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_EVSCAN = 3'd3;
  localparam logic [2:0] S_EVICT = 3'd4;
  localparam logic [2:0] S_ANSWER = 3'd5;

  // configuration
  logic [5:0]       history_limit;
  logic [HeldW-1:0] quarantine_limit;
  logic             abort_on_double;

  // table storage
  logic [AddrW-1:0] entry_address [HISTORY_DEPTH];
  logic [SizeW-1:0] entry_bytes   [HISTORY_DEPTH];
  logic [AgeW-1:0]  entry_age     [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0] entry_quarantined;
  logic [HISTORY_DEPTH-1:0] entry_valid;

  logic [HeldW-1:0] held_bytes;
  logic [AgeW-1:0]  next_age;
  logic [CntW-1:0]  dfree_total;
  logic [NumW-1:0]  valid_count;

  logic [2:0]       state;
  logic [NumW-1:0]  scan_pos;
  logic             inserted;
  logic             hit;
  req_t             cur;
  logic [AddrW-1:0] key;

  scan_t           flags;
  logic [IdxW-1:0] match_idx, free_idx, old_idx;
  logic [IdxW-1:0] slot;
  logic            scan_clear, scan_step;
  logic [NumW-1:0] lim;
  logic            qon;
  logic [HeldW-1:0] add_bytes;

  // bytes leaving the held total when an entry is dropped
  function automatic logic [HeldW-1:0] drop_amount(input logic quar,
                                                   input logic [SizeW-1:0] bytes,
                                                   input logic [HeldW-1:0] held);
    logic [HeldW-1:0] b;
    b = HeldW'(bytes);
    if (!quar) return '0;
    return (b <= held) ? b : held;
  endfunction

  assign slot       = scan_pos[IdxW-1:0];
  assign scan_step  = (state == S_SCAN || state == S_EVSCAN);
  assign scan_clear = (state == S_IDLE) || (state == S_DECIDE) || (state == S_EVICT);
  assign busy       = (state != S_IDLE);
  assign cfg_ready  = !busy;
  assign lim = (history_limit > 6'(HISTORY_DEPTH)) ? NumW'(HISTORY_DEPTH)
                                                   : NumW'(history_limit);
  assign key = (ADDR_BITS >= AddrW) ? req.addr
             : (req.addr & ((AddrW'(1) << ADDR_BITS) - AddrW'(1)));
  assign qon       = (quarantine_limit != '0);
  assign add_bytes = qon ? HeldW'(cur.obj_size) : '0;

  faqt_scan #(.IdxW(IdxW)) u_scan (
    .clk        (clk),
    .clear      (scan_clear),
    .step       (scan_step),
    .slot       (slot),
    .slot_valid (entry_valid[slot]),
    .addr_eq    (entry_address[slot] == cur.addr),
    .slot_age   (entry_age[slot]),
    .flags      (flags),
    .match_idx  (match_idx),
    .free_idx   (free_idx),
    .old_idx    (old_idx)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      history_limit    <= 6'd32;
      quarantine_limit <= '0;
      abort_on_double  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_HIST:  history_limit    <= cfg_data[5:0];
        CFG_QLIM:  quarantine_limit <= cfg_data[HeldW-1:0];
        CFG_ABORT: abort_on_double  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // drop of the oldest entry is needed while limits are exceeded
  logic over;
  assign over = (valid_count != '0) &&
                ((valid_count > lim) || (held_bytes > quarantine_limit));

  // result strobe: answers and quarantined releases
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= (state == S_ANSWER) ||
                   ((state == S_EVICT) && entry_quarantined[old_idx]);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      entry_valid       <= '0;
      held_bytes        <= '0;
      next_age          <= '0;
      dfree_total       <= '0;
      valid_count       <= '0;
      scan_pos          <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cur      <= '{req_type: req.req_type, addr: key, obj_size: req.obj_size};
            scan_pos <= '0;
            inserted <= 1'b0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          scan_pos <= scan_pos + NumW'(1);
          if (scan_pos == LastSlot) state <= S_DECIDE;
        end
        S_DECIDE: begin
          hit      <= flags.match;
          scan_pos <= '0;
          case (cur.req_type)
            REQ_RECORD: begin
              if (flags.match) begin
                // the matching slot is reused in place
                held_bytes <= held_bytes - drop_amount(entry_quarantined[match_idx],
                              entry_bytes[match_idx], held_bytes) + add_bytes;
                entry_address[match_idx] <= cur.addr;
                entry_bytes[match_idx]   <= cur.obj_size;
                entry_age[match_idx]     <= next_age;
                entry_quarantined[match_idx] <= qon;
                next_age <= next_age + AgeW'(1);
                inserted <= 1'b1;
                state    <= S_EVSCAN;
              end else if (flags.any_free) begin
                held_bytes <= held_bytes + add_bytes;
                entry_address[free_idx] <= cur.addr;
                entry_bytes[free_idx]   <= cur.obj_size;
                entry_age[free_idx]     <= next_age;
                entry_quarantined[free_idx] <= qon;
                entry_valid[free_idx]   <= 1'b1;
                valid_count <= valid_count + NumW'(1);
                next_age    <= next_age + AgeW'(1);
                inserted    <= 1'b1;
                state       <= S_EVSCAN;
              end else begin
                // full table: evict oldest first, then insert
                state <= S_EVICT;
              end
            end
            REQ_DCHECK: begin
              if (flags.match && dfree_total != '1)
                dfree_total <= dfree_total + CntW'(1);
              state <= S_ANSWER;
            end
            REQ_FORGET: begin
              if (flags.match) begin
                held_bytes <= held_bytes - drop_amount(entry_quarantined[match_idx],
                              entry_bytes[match_idx], held_bytes);
                entry_valid[match_idx] <= 1'b0;
                valid_count            <= valid_count - NumW'(1);
              end
              state <= S_ANSWER;
            end
            REQ_CLEAR: begin
              inserted <= 1'b1;
              state    <= S_EVSCAN;
            end
            default: state <= S_ANSWER;
          endcase
        end
        S_EVSCAN: begin
          scan_pos <= (scan_pos == LastSlot) ? '0 : scan_pos + NumW'(1);
          if (scan_pos == LastSlot) begin
            if (cur.req_type == REQ_CLEAR) begin
              if (valid_count != '0) begin
                state <= S_EVICT;
              end else begin
                state       <= S_ANSWER;
                held_bytes  <= '0;
                dfree_total <= '0;
              end
            end else begin
              state <= over ? S_EVICT : S_ANSWER;
            end
          end
        end
        S_EVICT: begin
          if (entry_quarantined[old_idx]) begin
            res <= '{kind: 1'b1, out_addr: entry_address[old_idx], hit: 1'b0,
                     keep_quarantined: 1'b0, abort_request: 1'b0,
                     double_free_total: dfree_total, last: 1'b0};
          end
          if (inserted) begin
            held_bytes <= held_bytes - drop_amount(entry_quarantined[old_idx],
                          entry_bytes[old_idx], held_bytes);
            entry_valid[old_idx] <= 1'b0;
            valid_count          <= valid_count - NumW'(1);
          end else begin
            // full table case: slot taken by the new entry
            held_bytes <= held_bytes - drop_amount(entry_quarantined[old_idx],
                          entry_bytes[old_idx], held_bytes) + add_bytes;
            entry_address[old_idx] <= cur.addr;
            entry_bytes[old_idx]   <= cur.obj_size;
            entry_age[old_idx]     <= next_age;
            entry_quarantined[old_idx] <= qon;
            next_age               <= next_age + AgeW'(1);
            inserted               <= 1'b1;
          end
          scan_pos <= '0;
          state    <= S_EVSCAN;
        end
        S_ANSWER: begin
          res <= '{kind: 1'b0, out_addr: cur.addr,
                   hit: (cur.req_type <= REQ_CLEAR) ? hit : 1'b0,
                   keep_quarantined: (cur.req_type == REQ_RECORD) && qon,
                   abort_request: (cur.req_type == REQ_DCHECK) && hit && abort_on_double,
                   double_free_total: dfree_total, last: 1'b1};
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_ready |-> state == S_IDLE) else $error("config taken while busy");
  a_res_busy: assert property (@(posedge clk) disable iff (rst)
    $past(state) == S_IDLE && !rst |-> !res_valid) else $error("result from idle");
  a_count: assert property (@(posedge clk) disable iff (rst)
    valid_count <= NumW'(HISTORY_DEPTH)) else $error("entry count overflow");

endmodule
